// ===== design/assert_macros.svh =====
// Assertion helpers for the charger supervisor design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHGSUP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charger supervisor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHGSUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charger supervisor: next-cycle check failed");

`endif

// ===== design/chgsup_pkg.sv =====
package chgsup_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int VALUE_W    = 16;
    localparam int PROD_W     = 28;
    localparam int MUL_STEPS  = SAMPLE_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Supply millivolts are 1200 mV * 4096 divided by the reference sample.
    localparam logic [PROD_W-1:0]   SUPPLY_NUM = PROD_W'(1200 * 4096);

    // Scale ratios reduced to lowest terms; truncation is unchanged by the reduction.
    localparam logic [SAMPLE_W-1:0] VIN_NUM  = SAMPLE_W'(224700 / 100);
    localparam logic [SAMPLE_W-1:0] VIN_DEN  = SAMPLE_W'(4700 / 100);
    localparam logic [SAMPLE_W-1:0] VOUT_NUM = SAMPLE_W'(71000 / 1000);
    localparam logic [SAMPLE_W-1:0] VOUT_DEN = SAMPLE_W'(15000 / 1000);
    localparam logic [SAMPLE_W-1:0] CUR_NUM  = SAMPLE_W'(1000 / 20);
    localparam logic [SAMPLE_W-1:0] CUR_DEN  = SAMPLE_W'(780 / 20);

    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_CHARGE = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_OVER   = 3'd4;
    localparam logic [2:0] MODE_SLEEP  = 3'd5;

    localparam logic [2:0] LED_KEEP   = 3'd0;
    localparam logic [2:0] LED_SLOW   = 3'd1;
    localparam logic [2:0] LED_CHARGE = 3'd2;
    localparam logic [2:0] LED_FAULT  = 3'd3;
    localparam logic [2:0] LED_OFF    = 3'd4;

    localparam logic [2:0] CFG_OVER_VOLTAGE  = 3'd0;
    localparam logic [2:0] CFG_UNDER_VOLTAGE = 3'd1;
    localparam logic [2:0] CFG_SLEEP_VOLTAGE = 3'd2;
    localparam logic [2:0] CFG_MIN_CURRENT   = 3'd3;
    localparam logic [2:0] CFG_CHARGE_SUPPLY = 3'd4;
    localparam logic [2:0] CFG_HOLD_TICKS    = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_input;
        logic [SAMPLE_W-1:0] adc_current;
        logic [SAMPLE_W-1:0] adc_output;
        logic [SAMPLE_W-1:0] adc_reference;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         next_state;
        logic               buck_enable;
        logic [2:0]         led_pattern;
        logic               enter_sleep;
        logic [VALUE_W-1:0] input_mv;
        logic [VALUE_W-1:0] output_mv;
        logic [VALUE_W-1:0] current_ma;
        logic [VALUE_W-1:0] supply_mv;
    } out_item_t;

    function automatic logic [VALUE_W-1:0] sat16(input logic [PROD_W-1:0] v);
        return (|v[PROD_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : v[VALUE_W-1:0];
    endfunction

endpackage

// ===== design/chgsup_in_if.sv =====
interface chgsup_in_if import chgsup_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/chgsup_out_if.sv =====
interface chgsup_out_if import chgsup_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/chgsup_sdiv.sv =====
module chgsup_sdiv import chgsup_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [SAMPLE_W-1:0] divisor,
    output logic                done,
    output logic [PROD_W-1:0]   quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/chgsup_lane.sv =====
module chgsup_lane import chgsup_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [VALUE_W-1:0]  supply,
    input  logic [SAMPLE_W-1:0] coef_num,
    input  logic [SAMPLE_W-1:0] coef_den,
    output logic                done,
    output logic [VALUE_W-1:0]  value
);

    localparam logic [1:0] LANE_IDLE = 2'd0;
    localparam logic [1:0] LANE_MUL1 = 2'd1;
    localparam logic [1:0] LANE_MUL2 = 2'd2;
    localparam logic [1:0] LANE_DIV  = 2'd3;

    logic [1:0]           phase_reg, phase_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  mult_reg, mult_next;
    logic [VALUE_W-1:0]   mcand_reg, mcand_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]    sum;
    logic                 div_start;
    logic                 div_done;
    logic [PROD_W-1:0]    div_quo;

    // Shift-add multiply, one multiplier bit per cycle, MSB first.
    assign sum = {acc_reg[PROD_W-2:0], 1'b0}
               + (mult_reg[SAMPLE_W-1] ? PROD_W'(mcand_reg) : '0);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mult_next  = mult_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        div_start  = 1'b0;
        unique case (phase_reg)
            LANE_IDLE:
            begin
                if (start)
                begin
                    phase_next = LANE_MUL1;
                    cnt_next   = MUL_CNT_W'(MUL_STEPS - 1);
                    mult_next  = sample;
                    mcand_next = supply;
                    acc_next   = '0;
                end
            end
            LANE_MUL1:
            begin
                acc_next  = sum;
                mult_next = {mult_reg[SAMPLE_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // The product divided by 4096 becomes the next multiplicand.
                    phase_next = LANE_MUL2;
                    mcand_next = sum[PROD_W-1 -: VALUE_W];
                    acc_next   = '0;
                    mult_next  = coef_num;
                    cnt_next   = MUL_CNT_W'(MUL_STEPS - 1);
                end
            end
            LANE_MUL2:
            begin
                acc_next  = sum;
                mult_next = {mult_reg[SAMPLE_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    phase_next = LANE_DIV;
                    div_start  = 1'b1;
                end
            end
            LANE_DIV:
            begin
                if (div_done)
                begin
                    phase_next = LANE_IDLE;
                end
            end
            default:
            begin
                phase_next = LANE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LANE_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg  <= mult_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    chgsup_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (coef_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign done  = div_done;
    assign value = sat16(div_quo);

endmodule

// ===== design/charger_supervisor_fsm.sv =====
// Charger supervisor. Each request on the adc channel carries one set of four
// 12-bit converter samples; each produces exactly one item on the status channel
// with the new charger state, buck enable, LED pattern code, sleep request and
// the computed input, output, current and supply values, saturated at 65535.
// Thresholds are written through wr_en / wr_index / wr_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// An index above five is ignored. The supply division runs on a bit-serial
// divider, then three lanes run in parallel, each with two shift-add multiplies
// and a bit-serial divide; the control then moves the result to the output.
// One request is worked on at a time. The result sits in an output register;
// adc.ready rises again as soon as the result is registered, even if the
// receiver has not taken it yet. If the receiver stalls, a finished
// computation waits until the register frees.
// Reset clears the charger to init with the converter off and zero ticks, and
// loads the default thresholds.
`include "assert_macros.svh"

module charger_supervisor_fsm import chgsup_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [2:0]           wr_index,
    input  logic [VALUE_W-1:0]   wr_data,
    chgsup_in_if.sink            adc,
    chgsup_out_if.source         status
);

    localparam logic [1:0] CTL_IDLE   = 2'd0;
    localparam logic [1:0] CTL_SUPPLY = 2'd1;
    localparam logic [1:0] CTL_SCALE  = 2'd2;
    localparam logic [1:0] CTL_WRITE  = 2'd3;

    logic [1:0]          ctl_reg, ctl_next;
    in_item_t            sample_reg;
    logic [VALUE_W-1:0]  over_reg, under_reg, sleep_reg, min_cur_reg, csup_reg, hold_reg;
    logic [2:0]          mode_reg, mode_next;
    logic [VALUE_W-1:0]  ticks_reg, ticks_next;
    logic                buck_reg, buck_next;
    logic                res_valid_reg, res_valid_next;
    out_item_t           res_data_reg;

    logic                accept;
    logic                sup_done;
    logic [PROD_W-1:0]   sup_quo;
    logic [VALUE_W-1:0]  supply;
    logic [2:0]          lane_done;
    logic [VALUE_W-1:0]  vin, vout, cur;
    logic                load;
    logic [2:0]          mode_eff;
    logic [2:0]          led;
    logic                sleep_req;

    assign accept    = adc.valid && adc.ready;
    assign adc.ready = (ctl_reg == CTL_IDLE);
    assign load      = (ctl_reg == CTL_WRITE) && (!res_valid_reg || status.ready);

    // The divisor is read on every iteration, so it comes from the captured request.
    chgsup_sdiv u_supply_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (SUPPLY_NUM),
        .divisor  (sample_reg.adc_reference),
        .done     (sup_done),
        .quotient (sup_quo)
    );

    // A zero reference makes every quotient bit one, which saturates as required.
    assign supply = sat16(sup_quo);

    chgsup_lane u_vin (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sup_done),
        .sample   (sample_reg.adc_input),
        .supply   (supply),
        .coef_num (VIN_NUM),
        .coef_den (VIN_DEN),
        .done     (lane_done[0]),
        .value    (vin)
    );

    chgsup_lane u_vout (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sup_done),
        .sample   (sample_reg.adc_output),
        .supply   (supply),
        .coef_num (VOUT_NUM),
        .coef_den (VOUT_DEN),
        .done     (lane_done[1]),
        .value    (vout)
    );

    chgsup_lane u_cur (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sup_done),
        .sample   (sample_reg.adc_current),
        .supply   (supply),
        .coef_num (CUR_NUM),
        .coef_den (CUR_DEN),
        .done     (lane_done[2]),
        .value    (cur)
    );

    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    ctl_next = CTL_SUPPLY;
                end
            end
            CTL_SUPPLY:
            begin
                if (sup_done)
                begin
                    ctl_next = CTL_SCALE;
                end
            end
            CTL_SCALE:
            begin
                if (lane_done[0])
                begin
                    ctl_next = CTL_WRITE;
                end
            end
            CTL_WRITE:
            begin
                if (load)
                begin
                    ctl_next = CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    // Charger state machine; over-voltage overrides the stored state first.
    always_comb
    begin
        mode_eff   = (vin > over_reg) ? MODE_OVER : mode_reg;
        mode_next  = mode_eff;
        buck_next  = buck_reg;
        ticks_next = ticks_reg;
        led        = LED_KEEP;
        sleep_req  = 1'b0;
        unique case (mode_eff)
            MODE_INIT:
            begin
                buck_next = 1'b0;
                if (vin < over_reg && vin > under_reg)
                begin
                    mode_next = MODE_START;
                end
                else
                begin
                    if (vin < sleep_reg)
                    begin
                        mode_next = MODE_SLEEP;
                    end
                    led = LED_SLOW;
                end
            end
            MODE_START:
            begin
                buck_next = 1'b1;
                mode_next = MODE_CHARGE;
            end
            MODE_CHARGE:
            begin
                led = LED_CHARGE;
                if (vin < under_reg)
                begin
                    mode_next = MODE_INIT;
                end
                else if (cur < min_cur_reg && ticks_reg > hold_reg && supply > csup_reg)
                begin
                    // The counter is cleared and then counts this step.
                    mode_next  = MODE_STOP;
                    ticks_next = VALUE_W'(1);
                end
                else
                begin
                    ticks_next = ticks_reg + 1'b1;
                end
            end
            MODE_STOP:
            begin
                buck_next = 1'b0;
                mode_next = (cur < min_cur_reg) ? MODE_SLEEP : MODE_INIT;
            end
            MODE_OVER:
            begin
                led       = LED_FAULT;
                buck_next = 1'b0;
                if (vin < over_reg)
                begin
                    mode_next = MODE_INIT;
                end
            end
            MODE_SLEEP:
            begin
                led       = LED_OFF;
                sleep_req = 1'b1;
                mode_next = MODE_INIT;
            end
            default:
            begin
                mode_next = MODE_INIT;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !status.ready;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CTL_IDLE;
            res_valid_reg <= 1'b0;
            mode_reg      <= MODE_INIT;
            ticks_reg     <= '0;
            buck_reg      <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            res_valid_reg <= res_valid_next;
            if (load)
            begin
                mode_reg  <= mode_next;
                ticks_reg <= ticks_next;
                buck_reg  <= buck_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_reg    <= VALUE_W'(22000);
            under_reg   <= VALUE_W'(5000);
            sleep_reg   <= VALUE_W'(1000);
            min_cur_reg <= VALUE_W'(200);
            csup_reg    <= VALUE_W'(2600);
            hold_reg    <= VALUE_W'(10);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_OVER_VOLTAGE:  over_reg    <= wr_data;
                CFG_UNDER_VOLTAGE: under_reg   <= wr_data;
                CFG_SLEEP_VOLTAGE: sleep_reg   <= wr_data;
                CFG_MIN_CURRENT:   min_cur_reg <= wr_data;
                CFG_CHARGE_SUPPLY: csup_reg    <= wr_data;
                CFG_HOLD_TICKS:    hold_reg    <= wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= adc.data;
        end
        if (load)
        begin
            res_data_reg.next_state  <= mode_next;
            res_data_reg.buck_enable <= buck_next;
            res_data_reg.led_pattern <= led;
            res_data_reg.enter_sleep <= sleep_req;
            res_data_reg.input_mv    <= vin;
            res_data_reg.output_mv   <= vout;
            res_data_reg.current_ma  <= cur;
            res_data_reg.supply_mv   <= supply;
        end
    end

    assign status.valid = res_valid_reg;
    assign status.data  = res_data_reg;

    `CHGSUP_ASSERT_IMPL(a_lanes_in_step, clk, rst_n, lane_done[0], lane_done[1] && lane_done[2])
    `CHGSUP_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, ctl_reg == CTL_SUPPLY)
    `CHGSUP_ASSERT_IMPL(a_mode_legal, clk, rst_n, 1'b1, mode_reg <= MODE_SLEEP)
    `CHGSUP_ASSERT_IMPL(a_sleep_led, clk, rst_n, res_valid_reg && res_data_reg.enter_sleep, res_data_reg.led_pattern == LED_OFF)

endmodule
